// ===== sv/mtwd_pkg.sv =====
// ----------------------------------------------------------------------------
// mtwd_pkg: shared types and constants for the heartbeat watchdog
// Opcodes, register indexes, field widths and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package mtwd_pkg;

   // field widths
   localparam int unsigned OpW       = 2;
   localparam int unsigned TaskW     = 4;
   localparam int unsigned FeedW     = 16;
   localparam int unsigned MaskW     = 4;
   localparam int unsigned CountW    = 12;
   localparam int unsigned CodeW     = 3;
   localparam int unsigned DivW      = 8;
   localparam int unsigned CsrIdxW   = 2;
   localparam int unsigned CsrDataW  = 16;
   localparam int unsigned ReqDataW  = 8;
   localparam int unsigned RspDataW  = 16;

   localparam int unsigned NumTasksDefault = 4;

   // register reset values
   localparam logic [FeedW-1:0]  MinIterReset  = 16'd1;
   localparam logic [MaskW-1:0]  MaskReset     = 4'd7;
   localparam logic [CountW-1:0] ReloadReset   = 12'd1400;
   localparam logic [CodeW-1:0]  CodeReset     = 3'd0;
   localparam logic [CodeW-1:0]  CodeMax       = 3'd6;

   typedef enum logic [OpW-1:0] {
      OP_FEED  = 2'd0,
      OP_CHECK = 2'd1,
      OP_TICK  = 2'd2,
      OP_START = 2'd3
   } op_type;

   typedef enum logic [CsrIdxW-1:0] {
      REG_MIN_ITER = 2'd0,
      REG_MASK     = 2'd1,
      REG_RELOAD   = 2'd2,
      REG_PRESCALE = 2'd3
   } reg_idx_type;

   // result word, lowest field last
   typedef struct packed {
      logic              running;
      logic [CountW-1:0] count_now;
      logic              tasks_alive;
      logic              watchdog_reset;
   } result_type;

endpackage

`default_nettype wire

// ===== sv/multi_task_heartbeat_watchdog_core.sv =====
// ----------------------------------------------------------------------------
// multi_task_heartbeat_watchdog_core
// Task heartbeat monitor combined with a prescaled down-counting watchdog.
// ----------------------------------------------------------------------------
// Usage:
//   Each req word is one event: feed (with a task index), periodic check,
//   low-speed watchdog tick, or start. Every event yields exactly one rsp
//   word carrying the underflow flag, last check result, down-counter value
//   and running flag as they stand after the event.
//   The event updates state at the accepting edge and the result word is
//   registered in the output register, or in the skid register while the
//   receiver stalls. One event per cycle is sustained while req_tready is
//   high; each event is a single counter step plus a parallel task compare.
//   A two-entry result queue (output register plus skid register) keeps the
//   input open for one more word while the receiver stalls; req_tready drops
//   only once the skid register is occupied.
//   Reset clears all counters, stops the watchdog, sets tasks_alive and
//   loads the register defaults. The csr port writes one register per cycle
//   and is meant to be used while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_task_heartbeat_watchdog_core #(
   parameter int unsigned NUM_TASKS = mtwd_pkg::NumTasksDefault
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // config port
   input  wire logic                           csr_we,
   input  wire logic [mtwd_pkg::CsrIdxW-1:0]   csr_index,
   input  wire logic [mtwd_pkg::CsrDataW-1:0]  csr_wdata,
   // event stream
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [mtwd_pkg::ReqDataW-1:0]  req_tdata,  // opcode[1:0], task_index[5:2]
   // result stream
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [mtwd_pkg::RspDataW-1:0]       rsp_tdata   // watchdog_reset[0],
                                                           // tasks_alive[1],
                                                           // count_now[13:2], running[14]
);

   localparam int unsigned CountW = mtwd_pkg::CountW;
   localparam int unsigned FeedW  = mtwd_pkg::FeedW;
   localparam int unsigned DivW   = mtwd_pkg::DivW;

   // config registers
   logic [FeedW-1:0]            min_iter_ff;
   logic [mtwd_pkg::MaskW-1:0]  mask_ff;
   logic [CountW-1:0]           reload_ff;
   logic [mtwd_pkg::CodeW-1:0]  code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_iter_ff <= mtwd_pkg::MinIterReset;
         mask_ff     <= mtwd_pkg::MaskReset;
         reload_ff   <= mtwd_pkg::ReloadReset;
         code_ff     <= mtwd_pkg::CodeReset;
      end else if (csr_we) begin
         unique case (mtwd_pkg::reg_idx_type'(csr_index))
            mtwd_pkg::REG_MIN_ITER: min_iter_ff <= csr_wdata;
            mtwd_pkg::REG_MASK:     mask_ff     <= csr_wdata[mtwd_pkg::MaskW-1:0];
            mtwd_pkg::REG_RELOAD:   reload_ff   <= csr_wdata[CountW-1:0];
            mtwd_pkg::REG_PRESCALE: code_ff     <= csr_wdata[mtwd_pkg::CodeW-1:0];
            default: ;
         endcase
      end
   end

   // event decode
   logic                         accept;
   mtwd_pkg::op_type             op;
   logic [mtwd_pkg::TaskW-1:0]   task_idx;

   assign accept   = req_tvalid & req_tready;
   assign op       = mtwd_pkg::op_type'(req_tdata[mtwd_pkg::OpW-1:0]);
   assign task_idx = req_tdata[mtwd_pkg::OpW +: mtwd_pkg::TaskW];

   // feed counters
   logic [FeedW-1:0] feed_ff [NUM_TASKS];
   logic [NUM_TASKS-1:0] task_short;

   for (genvar i = 0; i < NUM_TASKS; i++) begin : g_task
      logic [FeedW-1:0] feed_in;

      always_comb begin
         feed_in = feed_ff[i];
         if (accept) begin
            if (op == mtwd_pkg::OP_CHECK) begin
               feed_in = '0;
            end else if (op == mtwd_pkg::OP_FEED && task_idx == mtwd_pkg::TaskW'(i)
                         && feed_ff[i] != {FeedW{1'b1}}) begin
               feed_in = feed_ff[i] + FeedW'(1);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            feed_ff[i] <= '0;
         end else begin
            feed_ff[i] <= feed_in;
         end
      end

      // only mask bits that exist count toward the check
      if (i < mtwd_pkg::MaskW) begin : g_mon
         assign task_short[i] = mask_ff[i] && (feed_ff[i] < min_iter_ff);
      end else begin : g_nomon
         assign task_short[i] = 1'b0;
      end
   end

   // watchdog state
   logic [DivW-1:0]   div_ff,     div_in;
   logic [CountW-1:0] down_ff,    down_in;
   logic              started_ff, started_in;
   logic              alive_ff,   alive_in;
   logic              fired;

   logic [mtwd_pkg::CodeW-1:0] code_sat;
   logic [DivW:0]              tick_div;
   logic [DivW:0]              div_next;

   assign code_sat = (code_ff > mtwd_pkg::CodeMax) ? mtwd_pkg::CodeMax : code_ff;
   assign tick_div = (DivW+1)'(4) << code_sat;
   assign div_next = {1'b0, div_ff} + (DivW+1)'(1);

   always_comb begin
      div_in     = div_ff;
      down_in    = down_ff;
      started_in = started_ff;
      alive_in   = alive_ff;
      fired      = 1'b0;
      if (accept) begin
         unique case (op)
            mtwd_pkg::OP_FEED: ;
            mtwd_pkg::OP_CHECK: begin
               alive_in = ~|task_short;
               if (alive_in && started_ff) begin
                  down_in = reload_ff;
               end
            end
            mtwd_pkg::OP_TICK: begin
               if (started_ff) begin
                  if (div_next >= tick_div) begin
                     div_in = '0;
                     if (down_ff == '0) begin
                        fired   = 1'b1;
                        down_in = reload_ff;
                     end else begin
                        down_in = down_ff - CountW'(1);
                     end
                  end else begin
                     div_in = div_next[DivW-1:0];
                  end
               end
            end
            mtwd_pkg::OP_START: begin
               started_in = 1'b1;
               down_in    = reload_ff;
               div_in     = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff     <= '0;
         down_ff    <= '0;
         started_ff <= 1'b0;
         alive_ff   <= 1'b1;
      end else begin
         div_ff     <= div_in;
         down_ff    <= down_in;
         started_ff <= started_in;
         alive_ff   <= alive_in;
      end
   end

   mtwd_pkg::result_type result;

   assign result.running        = started_in;
   assign result.count_now      = down_in;
   assign result.tasks_alive    = alive_in;
   assign result.watchdog_reset = fired;

   // result queue: output register plus skid register
   logic                 out_valid_ff,  out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   mtwd_pkg::result_type out_data_ff,   out_data_in;
   mtwd_pkg::result_type skid_data_ff,  skid_data_in;

   assign req_tready = ~skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept;
            out_data_in  = result;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = mtwd_pkg::RspDataW'(out_data_ff);

endmodule

`default_nettype wire

// ===== verif/multi_task_heartbeat_watchdog_core_tb.sv =====
// ----------------------------------------------------------------------------
// multi_task_heartbeat_watchdog_core_tb
// Self-checking bench for the task heartbeat monitor and prescaled watchdog.
// Directed tests and random event streams drive the req channel. An in-bench
// watchdog predictor computes each status word, and every rsp word is
// compared against the oldest prediction. Both channels idle at random, and
// one test holds the receiver off long enough to stall the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_task_heartbeat_watchdog_core_tb;

   localparam int NumTasks   = mtwd_pkg::NumTasksDefault;
   localparam int CycleLimit = 600000;

   localparam int unsigned TaskW    = mtwd_pkg::TaskW;
   localparam int unsigned FeedW    = mtwd_pkg::FeedW;
   localparam int unsigned MaskW    = mtwd_pkg::MaskW;
   localparam int unsigned CountW   = mtwd_pkg::CountW;
   localparam int unsigned CodeW    = mtwd_pkg::CodeW;
   localparam int unsigned DivW     = mtwd_pkg::DivW;
   localparam int unsigned CsrDataW = mtwd_pkg::CsrDataW;
   localparam int unsigned ReqDataW = mtwd_pkg::ReqDataW;
   localparam int unsigned RspDataW = mtwd_pkg::RspDataW;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   mtwd_pkg::reg_idx_type csr_index;
   logic [CsrDataW-1:0]   csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [ReqDataW-1:0]   req_tdata;   // opcode[1:0], task_index[5:2]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RspDataW-1:0]   rsp_tdata;   // watchdog_reset[0], tasks_alive[1],
                                       // count_now[13:2], running[14]

   multi_task_heartbeat_watchdog_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // predictor state and register shadow
   logic [FeedW-1:0]  feed_tally [NumTasks];
   logic [DivW-1:0]   div_cnt;
   logic [CountW-1:0] down_cnt;
   logic              wd_running;
   logic              check_ok;
   logic [FeedW-1:0]  min_iter_reg;
   logic [MaskW-1:0]  mask_reg;
   logic [CountW-1:0] reload_reg;
   logic [CodeW-1:0]  code_reg;

   mtwd_pkg::result_type expected_status_q [$];

   int  fail_count;
   int  cycle_count;
   int  words_sent;
   int  feeds_sent;
   int  checks_sent;
   int  checks_failed;
   int  underflows;
   int  stall_left;
   int  hold_off;
   bit  no_idle;

   mtwd_pkg::result_type got_status;
   mtwd_pkg::result_type want_status;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("multi_task_heartbeat_watchdog_core regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor
   function automatic mtwd_pkg::result_type apply_event(mtwd_pkg::op_type op,
                                                        logic [TaskW-1:0] idx);
      mtwd_pkg::result_type r;
      logic        fired;
      int unsigned divide_by;
      int unsigned next_div;
      int          i;
      fired = 1'b0;
      case (op)
         mtwd_pkg::OP_FEED: begin
            if (idx < NumTasks && feed_tally[idx] != 16'hFFFF)
               feed_tally[idx]++;
            feeds_sent++;
         end
         mtwd_pkg::OP_CHECK: begin
            check_ok = 1'b1;
            for (i = 0; i < NumTasks && i < 4; i++)
               if (mask_reg[i] && feed_tally[i] < min_iter_reg)
                  check_ok = 1'b0;
            for (i = 0; i < NumTasks; i++)
               feed_tally[i] = '0;
            if (check_ok && wd_running)
               down_cnt = reload_reg;
            checks_sent++;
            if (!check_ok)
               checks_failed++;
         end
         mtwd_pkg::OP_TICK: begin
            if (wd_running) begin
               divide_by = 4 << ((code_reg > mtwd_pkg::CodeMax) ? mtwd_pkg::CodeMax
                                                                 : code_reg);
               next_div  = div_cnt + 1;
               // a count left over from a larger divider ends the period at once
               if (next_div >= divide_by) begin
                  div_cnt = '0;
                  if (down_cnt == '0) begin
                     fired    = 1'b1;
                     down_cnt = reload_reg;
                     underflows++;
                  end else begin
                     down_cnt--;
                  end
               end else begin
                  div_cnt = next_div[DivW-1:0];
               end
            end
         end
         default: begin
            wd_running = 1'b1;
            down_cnt   = reload_reg;
            div_cnt    = '0;
         end
      endcase
      r.watchdog_reset = fired;
      r.tasks_alive    = check_ok;
      r.count_now      = down_cnt;
      r.running        = wd_running;
      return r;
   endfunction

   // ------------------------------------------------------------ result side
   initial begin
      rsp_tready = 1'b0;
      stall_left = 0;
      hold_off   = 0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_tready = 1'b0;
         end else if (hold_off > 0) begin
            rsp_tready = 1'b0;
            hold_off--;
         end else if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_status = mtwd_pkg::result_type'(rsp_tdata[$bits(mtwd_pkg::result_type)-1:0]);
         if (expected_status_q.size() == 0) begin
            $error("status word with none expected: %h", rsp_tdata);
            fail_count++;
         end else begin
            want_status = expected_status_q.pop_front();
            if (got_status.watchdog_reset !== want_status.watchdog_reset) begin
               $error("watchdog_reset: expected %0d, got %0d",
                      want_status.watchdog_reset, got_status.watchdog_reset);
               fail_count++;
            end
            if (got_status.tasks_alive !== want_status.tasks_alive) begin
               $error("tasks_alive: expected %0d, got %0d",
                      want_status.tasks_alive, got_status.tasks_alive);
               fail_count++;
            end
            if (got_status.count_now !== want_status.count_now) begin
               $error("count_now: expected %0d, got %0d",
                      want_status.count_now, got_status.count_now);
               fail_count++;
            end
            if (got_status.running !== want_status.running) begin
               $error("running: expected %0d, got %0d",
                      want_status.running, got_status.running);
               fail_count++;
            end
         end
         stall_left = no_idle ? 0 : $urandom_range(0, 11);
      end
   end

   // ------------------------------------------------------------ event side
   task automatic send_event(mtwd_pkg::op_type op, logic [TaskW-1:0] idx);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = {2'b00, idx, op};
      req_tvalid = 1'b1;
      do begin
         @(posedge clock);
      end while (!req_tready);
      expected_status_q.push_back(apply_event(op, idx));
      words_sent++;
   endtask

   // wait for every status word before touching registers
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      wait (expected_status_q.size() == 0);
      repeat (3) @(negedge clock);
   endtask

   // caller sits at a falling edge with the block idle
   task automatic write_reg(mtwd_pkg::reg_idx_type idx, logic [CsrDataW-1:0] value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      case (idx)
         mtwd_pkg::REG_MIN_ITER: min_iter_reg = value[FeedW-1:0];
         mtwd_pkg::REG_MASK:     mask_reg     = value[MaskW-1:0];
         mtwd_pkg::REG_RELOAD:   reload_reg   = value[CountW-1:0];
         default:                code_reg     = value[CodeW-1:0];
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // ------------------------------------------------------------ tests
   task automatic test_before_start();
      send_event(mtwd_pkg::OP_TICK, 4'd0);    // not running: no effect
      send_event(mtwd_pkg::OP_CHECK, 4'd0);   // nobody fed: fails, no reload
      send_event(mtwd_pkg::OP_FEED, 4'd0);
      send_event(mtwd_pkg::OP_FEED, 4'd1);
      send_event(mtwd_pkg::OP_FEED, 4'd2);
      send_event(mtwd_pkg::OP_FEED, 4'd3);
      send_event(mtwd_pkg::OP_FEED, 4'd15);   // beyond task count
      send_event(mtwd_pkg::OP_CHECK, 4'd9);
   endtask

   task automatic test_underflow_restart();
      settle();
      write_reg(mtwd_pkg::REG_RELOAD, 16'd0);
      send_event(mtwd_pkg::OP_START, 4'd0);
      repeat (4) send_event(mtwd_pkg::OP_TICK, 4'd0);
      send_event(mtwd_pkg::OP_TICK, 4'd0);
      send_event(mtwd_pkg::OP_START, 4'd0);   // restart clears the divider
      send_event(mtwd_pkg::OP_TICK, 4'd0);
   endtask

   task automatic test_divider_shrink();
      settle();
      write_reg(mtwd_pkg::REG_PRESCALE, 16'd7);
      write_reg(mtwd_pkg::REG_RELOAD, 16'd4095);
      send_event(mtwd_pkg::OP_START, 4'd0);
      repeat (5) send_event(mtwd_pkg::OP_TICK, 4'd0);
      settle();
      write_reg(mtwd_pkg::REG_PRESCALE, 16'd0);
      send_event(mtwd_pkg::OP_TICK, 4'd0);
   endtask

   task automatic test_check_reload();
      send_event(mtwd_pkg::OP_FEED, 4'd0);
      send_event(mtwd_pkg::OP_FEED, 4'd1);
      send_event(mtwd_pkg::OP_FEED, 4'd2);
      send_event(mtwd_pkg::OP_CHECK, 4'd0);   // passes while running: reload
   endtask

   task automatic test_feed_threshold();
      settle();
      no_idle = 1'b1;
      write_reg(mtwd_pkg::REG_MIN_ITER, 16'd5);
      write_reg(mtwd_pkg::REG_MASK, 16'h0001);
      repeat (4) send_event(mtwd_pkg::OP_FEED, 4'd0);
      send_event(mtwd_pkg::OP_CHECK, 4'd0);   // one short: fails
      repeat (5) send_event(mtwd_pkg::OP_FEED, 4'd0);
      send_event(mtwd_pkg::OP_CHECK, 4'd0);   // exactly at the minimum: passes
      no_idle = 1'b0;
   endtask

   task automatic test_backpressure();
      settle();
      write_reg(mtwd_pkg::REG_MIN_ITER, 16'd1);
      write_reg(mtwd_pkg::REG_MASK, 16'h000F);
      write_reg(mtwd_pkg::REG_RELOAD, 16'd3);
      write_reg(mtwd_pkg::REG_PRESCALE, 16'd0);
      no_idle  = 1'b1;
      hold_off = 60;
      send_event(mtwd_pkg::OP_START, 4'd0);
      repeat (24) send_event(mtwd_pkg::op_type'($urandom_range(0, 2)),
                             4'($urandom_range(0, 3)));
      no_idle = 1'b0;
   endtask

   task automatic test_random_phases();
      int               phase;
      int               n;
      int               pick;
      logic [TaskW-1:0] idx;
      logic [15:0]      junk;
      for (phase = 0; phase < 7; phase++) begin
         settle();
         junk = 16'($urandom);
         if (phase == 0) begin
            write_reg(mtwd_pkg::REG_MIN_ITER, 16'd0);
            write_reg(mtwd_pkg::REG_MASK, 16'h0000);
            write_reg(mtwd_pkg::REG_RELOAD, 16'h0000);
            write_reg(mtwd_pkg::REG_PRESCALE, 16'h0000);
         end else if (phase == 1) begin
            write_reg(mtwd_pkg::REG_MIN_ITER, 16'hFFFF);
            write_reg(mtwd_pkg::REG_MASK, 16'hFFFF);
            write_reg(mtwd_pkg::REG_RELOAD, 16'hFFFF);
            write_reg(mtwd_pkg::REG_PRESCALE, 16'hFFFF);
         end else begin
            // upper bits of the mask, reload and prescale writes carry junk the register must drop
            write_reg(mtwd_pkg::REG_MIN_ITER, 16'($urandom_range(0, 6)));
            write_reg(mtwd_pkg::REG_MASK, (junk & 16'hFFF0) | 16'($urandom_range(0, 15)));
            write_reg(mtwd_pkg::REG_RELOAD, (junk & 16'hF000) | 16'($urandom_range(0, 12)));
            write_reg(mtwd_pkg::REG_PRESCALE,
                      (junk & 16'hFFF8) | 16'($urandom_range(0, 7) >> $urandom_range(0, 2)));
         end
         if ($urandom_range(0, 3) != 0)
            send_event(mtwd_pkg::OP_START, 4'($urandom));
         for (n = 0; n < 90; n++) begin
            if (n % 25 == 0)
               no_idle = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            idx  = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
            if (pick < 45)
               send_event(mtwd_pkg::OP_FEED, idx);
            else if (pick < 82)
               send_event(mtwd_pkg::OP_TICK, idx);
            else if (pick < 95)
               send_event(mtwd_pkg::OP_CHECK, idx);
            else
               send_event(mtwd_pkg::OP_START, idx);
         end
         no_idle = 1'b0;
      end
   endtask

   initial begin
      int i;
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_index  = mtwd_pkg::REG_MIN_ITER;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      no_idle    = 1'b0;
      fail_count = 0;
      min_iter_reg = mtwd_pkg::MinIterReset;
      mask_reg     = mtwd_pkg::MaskReset;
      reload_reg   = mtwd_pkg::ReloadReset;
      code_reg     = mtwd_pkg::CodeReset;
      for (i = 0; i < NumTasks; i++)
         feed_tally[i] = '0;
      div_cnt    = '0;
      down_cnt   = '0;
      wd_running = 1'b0;
      check_ok   = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_before_start();
      test_underflow_restart();
      test_divider_shrink();
      test_check_reload();
      test_feed_threshold();
      test_backpressure();
      test_random_phases();

      settle();
      repeat (5) @(posedge clock);
      $display("events: %0d sent, %0d feeds, %0d checks (%0d failed), %0d underflows",
               words_sent, feeds_sent, checks_sent, checks_failed, underflows);
      $display("registers swept through reset values, extremes and random settings");
      if (fail_count == 0)
         $display("multi_task_heartbeat_watchdog_core regression: pass");
      else
         $display("multi_task_heartbeat_watchdog_core regression: fail");
      $finish;
   end

endmodule
